### sv/ostq_pkg.sv
// ----------------------------------------------------------------------------
// ostq_pkg
// Shared types and constants of the one-shot timer queue: field widths,
// action and result codes, and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package ostq_pkg;

    // default sizing
    localparam int DEF_NUM_TIMERS = 8;
    localparam int DEF_COUNT_BITS = 32;

    // fixed field widths
    localparam int ACTION_W = 3;
    localparam int ID_W     = 3;
    localparam int VALUE_W  = 32;

    // most expiry events reported for one tick
    localparam int MAX_OUT = 8;
    localparam int OUTN_W  = $clog2(MAX_OUT + 1);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SET     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd4;

    // result kinds
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the accepted input transfer
        logic tick;      // decrement all running lanes, mark the due ones
        logic start;     // start the addressed lane if idle
        logic stop;      // stop the addressed lane if running
        logic set;       // load a new reload value into the addressed lane
        logic scan_clr;  // reset rank pointer and emit counter
        logic r_inc;     // advance the rank pointer
        logic emit;      // report and stop the matched due lane
        logic ack;       // load an acknowledgement into the output register
    } ostq_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_tick;
        logic is_start;
        logic is_stop;
        logic is_set;
        logic is_restart;
        logic match;     // a due lane holds the current rank
        logic r_done;    // rank pointer has passed all running lanes
        logic n_full;    // the per-tick event limit is reached
    } ostq_stat_t;

endpackage

### sv/one_shot_timer_queue_core.sv
// ----------------------------------------------------------------------------
// one_shot_timer_queue_core
// Bank of one-shot millisecond timers reporting expiries in start order.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready): s_action selects tick, start, stop,
// set_value or restart; s_timer_id names the timer; s_value is the new
// reload period for set_value. Output channel (m_valid/m_ready): each result
// carries m_kind (0 acknowledgement, 1 expiry), m_which_timer, m_running and
// m_last, which marks the final result of the input transfer.
// A control action gives one acknowledgement: the input is captured and
// decoded, the lane is updated (restart stops it and then starts it), and
// the acknowledgement is loaded into the output register once it is free,
// as s_ready returns. A tick decrements all running timers together, then a
// rank scan reports expired timers in start order: each scan cycle either
// reports the due timer at the current rank or steps the rank pointer past
// one that is not due, until all running timers are passed or MAX_OUT events
// are reported. Unknown actions and out-of-range timers finish with no result.
// One action is worked on at a time; s_ready is high only between actions.
// The result sits in an output register: when the receiver stalls, the scan
// holds until m_ready frees it, and a finished last result may wait while
// the next input transfer is taken. Reset clears all timers, reload values
// and counts and leaves the output channel empty.
// ----------------------------------------------------------------------------
module one_shot_timer_queue_core import ostq_pkg::*; #(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [ID_W-1:0]     s_timer_id,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic [ID_W-1:0]     m_which_timer,
    output logic                m_running,
    output logic                m_last
);

    ostq_cmd_t  cmd;
    ostq_stat_t stat;

    // sequencer
    ostq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // timer lanes and output register
    ostq_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_action      (s_action),
        .s_timer_id    (s_timer_id),
        .s_value       (s_value),
        .cmd           (cmd),
        .stat          (stat),
        .m_kind        (m_kind),
        .m_which_timer (m_which_timer),
        .m_running     (m_running),
        .m_last        (m_last)
    );

endmodule

### sv/ostq_ctrl.sv
// ----------------------------------------------------------------------------
// ostq_ctrl
// Sequencer of the timer queue: decodes one accepted action, steps the
// datapath through it and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module ostq_ctrl import ostq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  ostq_stat_t stat,
    output ostq_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_START2 = 3'd2;
    localparam logic [2:0] S_ACK    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // output register can take a new result this cycle
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (stat.is_tick) begin
                    cmd.tick     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end else if (stat.is_start) begin
                    cmd.start  = 1'b1;
                    state_next = S_ACK;
                end else if (stat.is_stop) begin
                    cmd.stop   = 1'b1;
                    state_next = S_ACK;
                end else if (stat.is_set) begin
                    cmd.stop   = 1'b1;
                    cmd.set    = 1'b1;
                    state_next = S_ACK;
                end else if (stat.is_restart) begin
                    cmd.stop   = 1'b1;
                    state_next = S_START2;
                end else begin
                    // unknown action or timer out of range: no result
                    state_next = S_IDLE;
                end
            end
            S_START2: begin
                cmd.start  = 1'b1;
                state_next = S_ACK;
            end
            S_ACK: begin
                if (out_free) begin
                    cmd.ack    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                priority if (stat.n_full || stat.r_done) begin
                    state_next = S_IDLE;
                end else if (stat.match) begin
                    // rank stays: the ranks above close up after the stop
                    cmd.emit = out_free;
                end else begin
                    cmd.r_inc = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.ack || cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // a new input is taken only after the previous one is fully done
    a_no_accept_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an action is in progress");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ack || cmd.emit) |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    // no acknowledgement is given during the expiry scan
    a_scan_no_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !cmd.ack)
        else $error("acknowledgement during expiry scan");

endmodule

### sv/ostq_datapath.sv
// ----------------------------------------------------------------------------
// ostq_datapath
// Timer lanes of the queue: per-timer reload, remaining count, running flag,
// start rank and due mark, the rank scan pointer and the output register.
// ----------------------------------------------------------------------------
module ostq_datapath import ostq_pkg::*; #(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [ID_W-1:0]     s_timer_id,
    input  logic [VALUE_W-1:0]  s_value,
    input  ostq_cmd_t           cmd,
    output ostq_stat_t          stat,
    output logic                m_kind,
    output logic [ID_W-1:0]     m_which_timer,
    output logic                m_running,
    output logic                m_last
);

    localparam int RANK_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W  = $clog2(NUM_TIMERS + 1);

    // captured input transfer
    logic [ACTION_W-1:0]   act_reg;
    logic [ID_W-1:0]       id_reg;
    logic [COUNT_BITS-1:0] val_reg;

    // timer lanes
    logic [COUNT_BITS-1:0] reload_reg [NUM_TIMERS];
    logic [COUNT_BITS-1:0] reload_next [NUM_TIMERS];
    logic [COUNT_BITS-1:0] rem_reg [NUM_TIMERS];
    logic [COUNT_BITS-1:0] rem_next [NUM_TIMERS];
    logic [RANK_W-1:0]     rank_reg [NUM_TIMERS];
    logic [RANK_W-1:0]     rank_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] run_reg, run_next;
    logic [NUM_TIMERS-1:0] due_reg, due_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    // scan state
    logic [CNT_W-1:0]  r_reg;
    logic [OUTN_W-1:0] n_reg;

    // output register
    logic            kind_reg;
    logic [ID_W-1:0] which_reg;
    logic            running_reg;
    logic            last_reg;

    logic [NUM_TIMERS-1:0] hit, match, stop_sel;
    logic [RANK_W-1:0]     tgt_rank, stop_rank;
    logic [ID_W-1:0]       enc_id;
    logic                  id_ok, other_due, stop_any, start_any;

    // lane decode, target rank, due-lane match at the current rank
    always_comb begin
        hit      = '0;
        match    = '0;
        tgt_rank = '0;
        enc_id   = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            hit[i]   = (int'(id_reg) == i);
            match[i] = run_reg[i] && due_reg[i] && (CNT_W'(rank_reg[i]) == r_reg);
            tgt_rank = tgt_rank | (hit[i] ? rank_reg[i] : '0);
            enc_id   = enc_id | (match[i] ? ID_W'(i) : '0);
        end
    end

    assign id_ok     = (int'(id_reg) < NUM_TIMERS);
    assign other_due = |(run_reg & due_reg & ~match);

    // one stop path shared by control stops and expiry reports
    assign stop_sel  = cmd.emit ? match : (cmd.stop ? (hit & run_reg) : '0);
    assign stop_rank = cmd.emit ? RANK_W'(r_reg) : tgt_rank;
    assign stop_any  = |stop_sel;
    assign start_any = cmd.start && |(hit & ~run_reg);

    // lane next values
    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            reload_next[i] = reload_reg[i];
            rem_next[i]    = rem_reg[i];
            rank_next[i]   = rank_reg[i];
            run_next[i]    = run_reg[i];
            due_next[i]    = due_reg[i];
            // tick: decrement, or expire at zero or one
            if (cmd.tick) begin
                if (run_reg[i] && (rem_reg[i] <= COUNT_BITS'(1))) begin
                    rem_next[i] = '0;
                    due_next[i] = 1'b1;
                end else if (run_reg[i]) begin
                    rem_next[i] = rem_reg[i] - COUNT_BITS'(1);
                    due_next[i] = 1'b0;
                end else begin
                    due_next[i] = 1'b0;
                end
            end
            // stop: clear the lane, later ranks close up
            if (stop_sel[i]) begin
                run_next[i]  = 1'b0;
                rank_next[i] = '0;
                due_next[i]  = 1'b0;
            end else if (stop_any && run_reg[i] && (rank_reg[i] > stop_rank)) begin
                rank_next[i] = rank_reg[i] - RANK_W'(1);
            end
            // set value
            if (cmd.set && hit[i]) begin
                reload_next[i] = val_reg;
                rem_next[i]    = val_reg;
            end
            // start an idle lane at the end of the rank order
            if (cmd.start && hit[i] && !run_reg[i]) begin
                rem_next[i]  = reload_reg[i];
                run_next[i]  = 1'b1;
                rank_next[i] = RANK_W'(count_reg);
            end
        end
    end

    // running count
    always_comb begin
        count_next = count_reg;
        if (stop_any) begin
            count_next = count_reg - CNT_W'(1);
        end else if (start_any) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // lane and scan registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= '0;
            due_reg   <= '0;
            count_reg <= '0;
            r_reg     <= '0;
            n_reg     <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                reload_reg[i] <= '0;
                rem_reg[i]    <= '0;
                rank_reg[i]   <= '0;
            end
        end else begin
            run_reg   <= run_next;
            due_reg   <= due_next;
            count_reg <= count_next;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                reload_reg[i] <= reload_next[i];
                rem_reg[i]    <= rem_next[i];
                rank_reg[i]   <= rank_next[i];
            end
            if (cmd.scan_clr) begin
                r_reg <= '0;
                n_reg <= '0;
            end else begin
                if (cmd.r_inc) begin
                    r_reg <= r_reg + CNT_W'(1);
                end
                if (cmd.emit) begin
                    n_reg <= n_reg + OUTN_W'(1);
                end
            end
        end
    end

    // input capture and output register (payload only)
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= s_action;
            id_reg  <= s_timer_id;
            val_reg <= s_value[COUNT_BITS-1:0];
        end
        if (cmd.ack) begin
            kind_reg    <= KIND_ACK;
            which_reg   <= id_reg;
            running_reg <= (act_reg == ACT_START) || (act_reg == ACT_RESTART);
            last_reg    <= 1'b1;
        end else if (cmd.emit) begin
            kind_reg    <= KIND_EXPIRY;
            which_reg   <= enc_id;
            running_reg <= 1'b0;
            last_reg    <= (n_reg == OUTN_W'(MAX_OUT - 1)) || !other_due;
        end
    end

    // status
    assign stat.is_tick    = (act_reg == ACT_TICK);
    assign stat.is_start   = id_ok && (act_reg == ACT_START);
    assign stat.is_stop    = id_ok && (act_reg == ACT_STOP);
    assign stat.is_set     = id_ok && (act_reg == ACT_SET);
    assign stat.is_restart = id_ok && (act_reg == ACT_RESTART);
    assign stat.match      = |match;
    assign stat.r_done     = (r_reg >= count_reg);
    assign stat.n_full     = (n_reg == OUTN_W'(MAX_OUT));

    assign m_kind        = kind_reg;
    assign m_which_timer = which_reg;
    assign m_running     = running_reg;
    assign m_last        = last_reg;

    // running count tracks the running flags
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(run_reg) == int'(count_reg))
        else $error("running count out of step with running flags");

    // ranks are unique, so at most one lane matches
    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match))
        else $error("two lanes share a rank");

    // an expiry report always names a due lane
    a_emit_match: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (|match))
        else $error("expiry report without a due lane");

    // never more events than the per-tick limit
    a_emit_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (n_reg < OUTN_W'(MAX_OUT)))
        else $error("per-tick event limit exceeded");

endmodule
